/* rtl/servo_scurve_step_profile_macros.svh */
// ----------------------------------------------------------------------------
// servo_scurve_step_profile_macros.svh
// Assertion shorthands used by the S-curve step profile top level.
// ----------------------------------------------------------------------------
`ifndef SERVO_SCURVE_STEP_PROFILE_MACROS_SVH
`define SERVO_SCURVE_STEP_PROFILE_MACROS_SVH

// cond must hold whenever trig is seen at a clock edge
`define SSCP_ASSERT_IMPLIES(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) else $error(msg);

// cond must hold in the cycle after trig
`define SSCP_ASSERT_NEXT(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) else $error(msg);

`endif

/* rtl/sscp_pkg.sv */
// ----------------------------------------------------------------------------
// sscp_pkg
// Shared widths, constants, register map and types of the S-curve profiler.
// ----------------------------------------------------------------------------
package sscp_pkg;

  // step sequencing
  localparam int MAX_STEPS   = 64;
  localparam int NW          = $clog2(MAX_STEPS + 1);  // step count
  localparam int IW          = $clog2(MAX_STEPS);      // step index
  localparam int HW          = NW - 1;                 // half step count

  // payload widths
  localparam int ID_W        = 8;
  localparam int POS_W       = 10;
  localparam int DIST_W      = POS_W;
  localparam int TIME_W      = 16;
  localparam int FACTOR_W    = 8;
  localparam int STEP_CFG_W  = 7;

  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 40;

  // short move threshold
  localparam int NEAR_LIMIT  = 50;
  localparam int NEAR_W      = $clog2(NEAR_LIMIT);

  // fixed point
  localparam int Q_FRAC      = 16;
  localparam int Q_W         = Q_FRAC + 1;             // 0 .. 1.0 inclusive
  localparam int T3_W        = Q_W + 1;
  localparam int THREE_Q16   = 3 * (1 << Q_FRAC);

  // dist / n : quotient bits per cycle and cycles
  localparam int FDIV_STEPS  = 5;
  localparam int FDIV_CYCLES = DIST_W / FDIV_STEPS;
  localparam int FDIV_CW     = $clog2(FDIV_CYCLES);

  // k / h fraction : bits per cycle and cycles
  localparam int BDIV_STEPS  = 8;
  localparam int BDIV_CYCLES = Q_FRAC / BDIV_STEPS;
  localparam int BDIV_CW     = $clog2(BDIV_CYCLES);

  // descriptor queue, depth a power of two
  localparam int QUEUE_DEPTH = 2;
  localparam int QAW         = $clog2(QUEUE_DEPTH);
  localparam int QCW         = $clog2(QUEUE_DEPTH + 1);

  // register file
  localparam int CFG_AW      = 5;
  localparam int CFG_DW      = 32;

  localparam logic [FACTOR_W-1:0]   RST_MS_PER_UNIT  = FACTOR_W'(2);
  localparam logic [TIME_W-1:0]     RST_TIME_FLOOR   = TIME_W'(100);
  localparam logic [TIME_W-1:0]     RST_TIME_CEIL    = TIME_W'(2000);
  localparam logic [STEP_CFG_W-1:0] RST_STEP_COUNT   = STEP_CFG_W'(20);
  localparam logic [TIME_W-1:0]     RST_SLOW_DELAY   = TIME_W'(100);
  localparam logic [TIME_W-1:0]     RST_FAST_DELAY   = TIME_W'(20);

  typedef enum logic [2:0] {
    REG_MS_PER_UNIT = 3'd0,
    REG_TIME_FLOOR  = 3'd1,
    REG_TIME_CEIL   = 3'd2,
    REG_STEP_COUNT  = 3'd3,
    REG_SLOW_DELAY  = 3'd4,
    REG_FAST_DELAY  = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [FACTOR_W-1:0]   ms_per_unit;
    logic [TIME_W-1:0]     time_floor;
    logic [TIME_W-1:0]     time_ceil;
    logic [STEP_CFG_W-1:0] step_count;
    logic [TIME_W-1:0]     slow_delay;
    logic [TIME_W-1:0]     fast_delay;
  } cfg_t;

  // one classified move, front to back
  typedef struct packed {
    logic              is_short;
    logic              up;
    logic [ID_W-1:0]   servo_id;
    logic [POS_W-1:0]  start_pos;
    logic [POS_W-1:0]  goal_pos;
    logic [DIST_W-1:0] size;
    logic [NW-1:0]     n;
    logic [TIME_W-1:0] move_time;
  } move_desc_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_flags_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_CLASS,
    F_DIV,
    F_PUSH
  } front_state_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_STEP,
    B_DIV,
    B_SQ,
    B_CUBE,
    B_SCALE,
    B_EMIT
  } back_state_t;

endpackage

/* rtl/sscp_front.sv */
// ----------------------------------------------------------------------------
// sscp_front
// Takes move requests, sorts short from long moves, works out the clamped
// time or the step size, and queues one descriptor per request.
// ----------------------------------------------------------------------------
module sscp_front
  import sscp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  cfg_t              cfg,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [ID_W-1:0]   in_servo_id,
  input  logic [POS_W-1:0]  in_start_pos,
  input  logic [POS_W-1:0]  in_goal_pos,
  input  q_flags_t          q_flags,
  output logic              q_push,
  output move_desc_t        q_desc
);

  front_state_t            state_r, state_nxt;
  move_desc_t              desc_r;
  logic [DIST_W-1:0]       dq_r;
  logic [NW-1:0]           rem_r;
  logic [FDIV_CW-1:0]      cnt_r;

  logic                    up;
  logic [DIST_W-1:0]       span;
  logic                    near;
  logic [NW-1:0]           n_sat;
  logic [NEAR_W+FACTOR_W-1:0] prod;
  logic [TIME_W-1:0]       prod_t;
  logic [TIME_W-1:0]       short_time;
  logic [DIST_W-1:0]       div_d;
  logic [NW-1:0]           div_r;
  logic [NW:0]             div_t;
  logic [DIST_W-1:0]       size_calc;

  assign up   = desc_r.goal_pos > desc_r.start_pos;
  assign span = up ? desc_r.goal_pos - desc_r.start_pos
                   : desc_r.start_pos - desc_r.goal_pos;
  assign near = span < DIST_W'(NEAR_LIMIT);

  // step count saturated to 2..MAX_STEPS
  always_comb begin
    if (cfg.step_count < STEP_CFG_W'(2)) begin
      n_sat = NW'(2);
    end else if (int'(cfg.step_count) > MAX_STEPS) begin
      n_sat = NW'(MAX_STEPS);
    end else begin
      n_sat = NW'(cfg.step_count);
    end
  end

  // single command time, only meaningful when span is below the threshold
  assign prod   = span[NEAR_W-1:0] * cfg.ms_per_unit;
  assign prod_t = TIME_W'(prod);

  always_comb begin
    if (prod_t < cfg.time_floor) begin
      short_time = cfg.time_floor;
    end else if (prod_t > cfg.time_ceil) begin
      short_time = cfg.time_ceil;
    end else begin
      short_time = prod_t;
    end
  end

  // restoring divide span / n, FDIV_STEPS quotient bits per cycle
  always_comb begin
    div_d = dq_r;
    div_r = rem_r;
    div_t = '0;
    for (int j = 0; j < FDIV_STEPS; j++) begin
      div_t = {div_r, div_d[DIST_W-1]};
      div_d = {div_d[DIST_W-2:0], 1'b0};
      if (div_t >= {1'b0, desc_r.n}) begin
        div_r    = NW'(div_t - {1'b0, desc_r.n});
        div_d[0] = 1'b1;
      end else begin
        div_r = div_t[NW-1:0];
      end
    end
    size_calc = (div_d == '0) ? DIST_W'(1) : div_d;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      F_IDLE: begin
        if (in_valid) begin
          desc_r.servo_id  <= in_servo_id;
          desc_r.start_pos <= in_start_pos;
          desc_r.goal_pos  <= in_goal_pos;
        end
      end
      F_CLASS: begin
        desc_r.up        <= up;
        desc_r.is_short  <= near;
        desc_r.move_time <= short_time;
        desc_r.n         <= n_sat;
        desc_r.size      <= DIST_W'(1);
        dq_r             <= span;
        rem_r            <= '0;
        cnt_r            <= '0;
      end
      F_DIV: begin
        dq_r        <= div_d;
        rem_r       <= div_r;
        cnt_r       <= cnt_r + FDIV_CW'(1);
        desc_r.size <= size_calc;
      end
      F_PUSH: begin
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    q_push    = 1'b0;
    unique case (state_r)
      F_IDLE: begin
        // no transfer while reset is held
        in_ready = rst_n;
        if (in_valid && in_ready) begin
          state_nxt = F_CLASS;
        end
      end
      F_CLASS: begin
        state_nxt = near ? F_PUSH : F_DIV;
      end
      F_DIV: begin
        if (cnt_r == FDIV_CW'(FDIV_CYCLES - 1)) begin
          state_nxt = F_PUSH;
        end
      end
      F_PUSH: begin
        if (!q_flags.full) begin
          q_push    = 1'b1;
          state_nxt = F_IDLE;
        end
      end
      default: begin
        state_nxt = F_IDLE;
      end
    endcase
  end

  assign q_desc = desc_r;

endmodule

/* rtl/sscp_fifo.sv */
// ----------------------------------------------------------------------------
// sscp_fifo
// Short descriptor queue between the request front end and the step engine.
// ----------------------------------------------------------------------------
module sscp_fifo
  import sscp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  move_desc_t push_desc,
  input  logic       pop,
  output move_desc_t pop_desc,
  output q_flags_t   flags
);

  move_desc_t       slot_r [QUEUE_DEPTH];
  logic [QAW-1:0]   wr_ptr_r;
  logic [QAW-1:0]   rd_ptr_r;
  logic [QCW-1:0]   count_r;

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QAW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QAW'(1);
      end
      unique case ({push, pop})
        2'b10:   count_r <= count_r + QCW'(1);
        2'b01:   count_r <= count_r - QCW'(1);
        default: count_r <= count_r;
      endcase
    end
  end

  assign pop_desc    = slot_r[rd_ptr_r];
  assign flags.full  = (count_r == QCW'(QUEUE_DEPTH));
  assign flags.empty = (count_r == '0);

endmodule

/* rtl/sscp_back.sv */
// ----------------------------------------------------------------------------
// sscp_back
// Step engine: walks a queued move, one command at a time, with the smoothstep
// delay of long moves from a short divider and three registered multiplies.
// ----------------------------------------------------------------------------
module sscp_back
  import sscp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  cfg_t              cfg,
  input  move_desc_t        q_desc,
  input  q_flags_t          q_flags,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [ID_W-1:0]   out_servo,
  output logic [POS_W-1:0]  out_pos,
  output logic [TIME_W-1:0] out_time,
  output logic              out_last
);

  back_state_t               state_r, state_nxt;
  move_desc_t                cur_r;
  logic [IW-1:0]             i_r;
  logic [POS_W-1:0]          pos_r;
  logic [POS_W-1:0]          nxt_pos_r;
  logic                      last_r;
  logic                      xint_r;
  logic [HW-1:0]             rem_r;
  logic [Q_FRAC-1:0]         frac_r;
  logic [BDIV_CW-1:0]        cnt_r;
  logic [2*Q_W-1:0]          sq_r;
  logic [Q_W-1:0]            s_r;
  logic [TIME_W+Q_W-1:0]     m_r;

  logic                      out_valid_r;
  logic [ID_W-1:0]           out_servo_r;
  logic [POS_W-1:0]          out_pos_r;
  logic [TIME_W-1:0]         out_time_r;
  logic                      out_last_r;

  logic [HW-1:0]             h;
  logic [NW-1:0]             i_ext;
  logic [NW-1:0]             k_full;
  logic [HW-1:0]             k;
  logic                      at_end;
  logic [POS_W-1:0]          gap;
  logic [POS_W-1:0]          step_pos;
  logic [POS_W-1:0]          next_pos;
  logic [HW-1:0]             div_r;
  logic [HW:0]               div_t;
  logic [Q_FRAC-1:0]         div_f;
  logic [Q_W-1:0]            x;
  logic [T3_W-1:0]           t3;
  logic [2*Q_W+T3_W-1:0]     cube;
  logic                      slow_ge;
  logic [TIME_W-1:0]         diff;
  logic [TIME_W+Q_FRAC+1:0]  v;
  logic [TIME_W-1:0]         delay;
  logic [TIME_W-1:0]         emit_time;
  logic                      slot_free;
  logic                      load;

  // step index folded around the middle: k = i below h, n-1-i after
  assign h      = cur_r.n[NW-1:1];
  assign i_ext  = NW'(i_r);
  assign k_full = cur_r.n - NW'(1) - i_ext;
  assign k      = (i_ext < {1'b0, h}) ? i_ext[HW-1:0] : k_full[HW-1:0];
  assign at_end = (i_ext == cur_r.n - NW'(1));

  // next position, capped at the goal
  assign gap      = cur_r.up ? cur_r.goal_pos - pos_r : pos_r - cur_r.goal_pos;
  assign step_pos = cur_r.up ? pos_r + cur_r.size : pos_r - cur_r.size;
  assign next_pos = (at_end || gap <= cur_r.size) ? cur_r.goal_pos : step_pos;

  // fraction bits of k/h, remainder always below h
  always_comb begin
    div_r = rem_r;
    div_f = frac_r;
    div_t = '0;
    for (int j = 0; j < BDIV_STEPS; j++) begin
      div_t = {div_r, 1'b0};
      div_f = {div_f[Q_FRAC-2:0], 1'b0};
      if (div_t >= {1'b0, h}) begin
        div_r    = HW'(div_t - {1'b0, h});
        div_f[0] = 1'b1;
      end else begin
        div_r = div_t[HW-1:0];
      end
    end
  end

  // s = x^2 * (3 - 2x), Q16
  assign x    = {xint_r, frac_r};
  assign t3   = T3_W'(THREE_Q16) - {x, 1'b0};
  assign cube = sq_r * t3;

  // delay = slow -/+ |slow - fast| * s
  assign slow_ge = cfg.slow_delay >= cfg.fast_delay;
  assign diff    = slow_ge ? cfg.slow_delay - cfg.fast_delay
                           : cfg.fast_delay - cfg.slow_delay;
  assign v       = slow_ge ? {2'b00, cfg.slow_delay, Q_FRAC'(0)} - {1'b0, m_r}
                           : {2'b00, cfg.slow_delay, Q_FRAC'(0)} + {1'b0, m_r};
  assign delay   = v[Q_FRAC+TIME_W-1:Q_FRAC];

  assign emit_time = cur_r.is_short ? cur_r.move_time : delay;
  assign slot_free = !out_valid_r || out_ready;
  assign load      = (state_r == B_EMIT) && slot_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      B_IDLE: begin
        if (!q_flags.empty) begin
          cur_r     <= q_desc;
          i_r       <= '0;
          pos_r     <= q_desc.start_pos;
          nxt_pos_r <= q_desc.goal_pos;
          last_r    <= 1'b1;
        end
      end
      B_STEP: begin
        nxt_pos_r <= next_pos;
        last_r    <= (next_pos == cur_r.goal_pos);
        xint_r    <= (k == h);
        rem_r     <= (k == h) ? '0 : k;
        frac_r    <= '0;
        cnt_r     <= '0;
      end
      B_DIV: begin
        rem_r  <= div_r;
        frac_r <= div_f;
        cnt_r  <= cnt_r + BDIV_CW'(1);
      end
      B_SQ: begin
        sq_r <= x * x;
      end
      B_CUBE: begin
        s_r <= cube[2*Q_FRAC+Q_W-1:2*Q_FRAC];
      end
      B_SCALE: begin
        m_r <= diff * s_r;
      end
      B_EMIT: begin
        if (slot_free && !last_r) begin
          i_r   <= i_r + IW'(1);
          pos_r <= nxt_pos_r;
        end
      end
      default: begin
      end
    endcase
  end

  // output register: the engine only waits here when a command is unclaimed
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_servo_r <= cur_r.servo_id;
      out_pos_r   <= nxt_pos_r;
      out_time_r  <= emit_time;
      out_last_r  <= last_r;
    end
  end

  always_comb begin
    state_nxt = state_r;
    q_pop     = 1'b0;
    unique case (state_r)
      B_IDLE: begin
        if (!q_flags.empty) begin
          q_pop     = 1'b1;
          state_nxt = q_desc.is_short ? B_EMIT : B_STEP;
        end
      end
      B_STEP:  state_nxt = B_DIV;
      B_DIV: begin
        if (cnt_r == BDIV_CW'(BDIV_CYCLES - 1)) begin
          state_nxt = B_SQ;
        end
      end
      B_SQ:    state_nxt = B_CUBE;
      B_CUBE:  state_nxt = B_SCALE;
      B_SCALE: state_nxt = B_EMIT;
      B_EMIT: begin
        if (slot_free) begin
          state_nxt = last_r ? B_IDLE : B_STEP;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_servo = out_servo_r;
  assign out_pos   = out_pos_r;
  assign out_time  = out_time_r;
  assign out_last  = out_last_r;

endmodule

/* rtl/servo_scurve_step_profile.sv */
// ----------------------------------------------------------------------------
// servo_scurve_step_profile
// Turns servo move requests into a run of S-curve timed servo commands.
// Input stream: one move request per transfer (servo id, start, goal).
// Output stream: one command per transfer (servo, position, time), tlast on
//   the final command of a request. A config port holds the six settings;
//   write them only while no request is in flight.
// Short moves (distance under 50) give one command; the front end takes no
//   new request until it has queued the descriptor of the last one.
// Long moves give up to N commands (N = saturated step_count). For each step
//   the step engine goes through B_STEP, the fraction divider in B_DIV, three
//   multiplies in B_SQ, B_CUBE and B_SCALE, and B_EMIT, where a stalled
//   receiver can hold it.
// A two-entry queue lets the front end classify the next request while the
//   step engine still works on the previous one.
// Reset (synchronous, rst_n low) empties the queue, drops any pending command
//   and loads the register defaults. A stalled receiver holds the command in
//   the output register; the step engine waits there, the queue fills and
//   then in_tready drops.
// ----------------------------------------------------------------------------
`include "servo_scurve_step_profile_macros.svh"

module servo_scurve_step_profile
  import sscp_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,

  // request stream
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,    // [7:0] servo_id, [17:8] start_pos,
                                              // [27:18] goal_pos, [31:28] zero

  // command stream
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,   // [7:0] cmd_servo, [17:8] cmd_pos,
                                              // [33:18] cmd_time, [39:34] zero
  output logic                   out_tlast,   // last_cmd

  // register port
  input  logic                   cfg_psel,
  input  logic                   cfg_penable,
  input  logic                   cfg_pwrite,
  input  logic [CFG_AW-1:0]      cfg_paddr,
  input  logic [CFG_DW-1:0]      cfg_pwdata,
  output logic [CFG_DW-1:0]      cfg_prdata,
  output logic                   cfg_pready
);

  cfg_t              cfg_r;
  logic              cfg_wr;
  reg_idx_t          reg_idx;

  logic              q_push;
  logic              q_pop;
  move_desc_t        front_desc;
  move_desc_t        back_desc;
  q_flags_t          q_flags;

  logic [ID_W-1:0]   cmd_servo;
  logic [POS_W-1:0]  cmd_pos;
  logic [TIME_W-1:0] cmd_time;

  // --------------------------------------------------------------------------
  // Register file. Zero wait states; writes land on the access phase.
  // Addresses past the last register read zero and ignore writes.
  // --------------------------------------------------------------------------
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign reg_idx    = reg_idx_t'(cfg_paddr[CFG_AW-1:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ms_per_unit <= RST_MS_PER_UNIT;
      cfg_r.time_floor  <= RST_TIME_FLOOR;
      cfg_r.time_ceil   <= RST_TIME_CEIL;
      cfg_r.step_count  <= RST_STEP_COUNT;
      cfg_r.slow_delay  <= RST_SLOW_DELAY;
      cfg_r.fast_delay  <= RST_FAST_DELAY;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_MS_PER_UNIT: cfg_r.ms_per_unit <= cfg_pwdata[FACTOR_W-1:0];
        REG_TIME_FLOOR:  cfg_r.time_floor  <= cfg_pwdata[TIME_W-1:0];
        REG_TIME_CEIL:   cfg_r.time_ceil   <= cfg_pwdata[TIME_W-1:0];
        REG_STEP_COUNT:  cfg_r.step_count  <= cfg_pwdata[STEP_CFG_W-1:0];
        REG_SLOW_DELAY:  cfg_r.slow_delay  <= cfg_pwdata[TIME_W-1:0];
        REG_FAST_DELAY:  cfg_r.fast_delay  <= cfg_pwdata[TIME_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_MS_PER_UNIT: cfg_prdata = CFG_DW'(cfg_r.ms_per_unit);
      REG_TIME_FLOOR:  cfg_prdata = CFG_DW'(cfg_r.time_floor);
      REG_TIME_CEIL:   cfg_prdata = CFG_DW'(cfg_r.time_ceil);
      REG_STEP_COUNT:  cfg_prdata = CFG_DW'(cfg_r.step_count);
      REG_SLOW_DELAY:  cfg_prdata = CFG_DW'(cfg_r.slow_delay);
      REG_FAST_DELAY:  cfg_prdata = CFG_DW'(cfg_r.fast_delay);
      default:         cfg_prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Front end: classify the request, clamp time or divide out the step size.
  // --------------------------------------------------------------------------
  sscp_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg_r),
    .in_valid     (in_tvalid),
    .in_ready     (in_tready),
    .in_servo_id  (in_tdata[7:0]),
    .in_start_pos (in_tdata[17:8]),
    .in_goal_pos  (in_tdata[27:18]),
    .q_flags      (q_flags),
    .q_push       (q_push),
    .q_desc       (front_desc)
  );

  // descriptor queue decouples request intake from command generation
  sscp_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_desc (front_desc),
    .pop       (q_pop),
    .pop_desc  (back_desc),
    .flags     (q_flags)
  );

  // --------------------------------------------------------------------------
  // Step engine: positions, smoothstep or clamped delays, one command per step.
  // --------------------------------------------------------------------------
  sscp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_desc    (back_desc),
    .q_flags   (q_flags),
    .q_pop     (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_servo (cmd_servo),
    .out_pos   (cmd_pos),
    .out_time  (cmd_time),
    .out_last  (out_tlast)
  );

  assign out_tdata = {6'b000000, cmd_time, cmd_pos, cmd_servo};

  // --------------------------------------------------------------------------
  // Checks
  // --------------------------------------------------------------------------
  `SSCP_ASSERT_IMPLIES(a_queue_no_overflow, q_push, !q_flags.full, "push into full queue")
  `SSCP_ASSERT_IMPLIES(a_queue_no_underflow, q_pop, !q_flags.empty, "pop from empty queue")
  `SSCP_ASSERT_NEXT(a_front_busy, in_tvalid && in_tready, !in_tready, "request taken while busy")

endmodule

/* tb/servo_scurve_step_profile_tb.sv */
// ----------------------------------------------------------------------------
// servo_scurve_step_profile_tb
// Self-checking bench for the S-curve step profiler. Move requests go in on
// the request stream. An in-bench profile model plans the expected command
// run for every accepted request. Each command taken from the output stream
// is checked field by field against the oldest planned command. Settings are
// changed over the APB port between phases while the block is idle. The
// phases vary the idle and stall patterns on both streams.
// ----------------------------------------------------------------------------

typedef struct {
  logic [sscp_pkg::ID_W-1:0]   servo;
  logic [sscp_pkg::POS_W-1:0]  pos;
  logic [sscp_pkg::TIME_W-1:0] ms;
  logic                        last;
} servo_cmd_t;

// Holds a copy of the settings, plans the command run of each request and
// compares returned commands against the plan in order.
class profile_checker;
  logic [sscp_pkg::FACTOR_W-1:0]   factor;
  logic [sscp_pkg::TIME_W-1:0]     t_min;
  logic [sscp_pkg::TIME_W-1:0]     t_max;
  logic [sscp_pkg::STEP_CFG_W-1:0] steps;
  logic [sscp_pkg::TIME_W-1:0]     slow_ms;
  logic [sscp_pkg::TIME_W-1:0]     fast_ms;
  servo_cmd_t                      planned_cmds[$];
  int                              errors;

  function new();
    factor  = sscp_pkg::RST_MS_PER_UNIT;
    t_min   = sscp_pkg::RST_TIME_FLOOR;
    t_max   = sscp_pkg::RST_TIME_CEIL;
    steps   = sscp_pkg::RST_STEP_COUNT;
    slow_ms = sscp_pkg::RST_SLOW_DELAY;
    fast_ms = sscp_pkg::RST_FAST_DELAY;
    errors  = 0;
  endfunction

  // byte address 4*index; anything past the map is dropped
  function void write_reg(logic [sscp_pkg::CFG_AW-1:0] addr, logic [31:0] value);
    case (sscp_pkg::reg_idx_t'(addr[sscp_pkg::CFG_AW-1:2]))
      sscp_pkg::REG_MS_PER_UNIT: factor  = value[sscp_pkg::FACTOR_W-1:0];
      sscp_pkg::REG_TIME_FLOOR:  t_min   = value[sscp_pkg::TIME_W-1:0];
      sscp_pkg::REG_TIME_CEIL:   t_max   = value[sscp_pkg::TIME_W-1:0];
      sscp_pkg::REG_STEP_COUNT:  steps   = value[sscp_pkg::STEP_CFG_W-1:0];
      sscp_pkg::REG_SLOW_DELAY:  slow_ms = value[sscp_pkg::TIME_W-1:0];
      sscp_pkg::REG_FAST_DELAY:  fast_ms = value[sscp_pkg::TIME_W-1:0];
      default: ;
    endcase
  endfunction

  // single-command time: the floor is checked first, then the ceiling
  function logic [15:0] move_ms(int unsigned span);
    longint unsigned t;
    t = 64'(span) * 64'(factor);
    if (t < 64'(t_min)) return t_min;
    if (t > 64'(t_max)) return t_max;
    return t[15:0];
  endfunction

  // smoothstep delay of step i out of n, Q16 truncation at each stage
  function logic [15:0] ramp_ms(int unsigned i, int unsigned n);
    longint unsigned half, k, x, s, v;
    half = 64'(n) / 64'd2;
    k = (64'(i) < half) ? 64'(i) : 64'(n) - 64'(i) - 64'd1;
    x = (k << 16) / half;
    if (x > 64'd65536) x = 64'd65536;
    s = (x * x * (64'd196608 - 64'd2 * x)) >> 32;
    v = 64'(slow_ms) << 16;
    if (slow_ms >= fast_ms) v = v - (64'(slow_ms) - 64'(fast_ms)) * s;
    else v = v + (64'(fast_ms) - 64'(slow_ms)) * s;
    return v[31:16];
  endfunction

  function void plan_cmd(logic [7:0] id, int unsigned pos, logic [15:0] ms, logic last);
    servo_cmd_t c;
    c.servo = id;
    c.pos   = pos[sscp_pkg::POS_W-1:0];
    c.ms    = ms;
    c.last  = last;
    planned_cmds.push_back(c);
  endfunction

  function void note_request(logic [sscp_pkg::IN_TDATA_W-1:0] data);
    logic [7:0]  id;
    int unsigned from_pos, to_pos, span, n, size, i, pos, nxt;
    bit          rising;
    id       = data[7:0];
    from_pos = 32'(data[17:8]);
    to_pos   = 32'(data[27:18]);
    rising   = to_pos > from_pos;
    span     = rising ? to_pos - from_pos : from_pos - to_pos;
    if (span < sscp_pkg::NEAR_LIMIT) begin
      plan_cmd(id, to_pos, move_ms(span), 1'b1);
      return;
    end
    n = 32'(steps);
    if (n < 2) n = 2;
    if (n > sscp_pkg::MAX_STEPS) n = sscp_pkg::MAX_STEPS;
    size = span / n;
    if (size < 1) size = 1;
    pos = from_pos;
    for (i = 0; i < n; i++) begin
      if (i == n - 1) nxt = to_pos;
      else if (rising) nxt = (pos + size > to_pos) ? to_pos : pos + size;
      else nxt = (pos < to_pos + size) ? to_pos : pos - size;
      plan_cmd(id, nxt, ramp_ms(i, n), nxt == to_pos);
      pos = nxt;
      if (pos == to_pos) break;
    end
  endfunction

  function void flag_error(string what);
    errors++;
    if (errors <= 10) $display("[%0t] mismatch: %s", $realtime, what);
  endfunction

  function void check_command(logic [sscp_pkg::OUT_TDATA_W-1:0] data, logic last);
    servo_cmd_t want;
    if (planned_cmds.size() == 0) begin
      flag_error($sformatf("unexpected command tdata=%h tlast=%b", data, last));
      return;
    end
    want = planned_cmds.pop_front();
    if (data[7:0] !== want.servo)
      flag_error($sformatf("cmd_servo exp %0d got %0d", want.servo, data[7:0]));
    if (data[17:8] !== want.pos)
      flag_error($sformatf("cmd_pos exp %0d got %0d", want.pos, data[17:8]));
    if (data[33:18] !== want.ms)
      flag_error($sformatf("cmd_time exp %0d got %0d", want.ms, data[33:18]));
    if (last !== want.last)
      flag_error($sformatf("last_cmd exp %b got %b", want.last, last));
  endfunction

  function int pending();
    return planned_cmds.size();
  endfunction
endclass

module servo_scurve_step_profile_tb;
  import sscp_pkg::*;

  localparam int POS_MAX       = (1 << POS_W) - 1;
  localparam int HOLD_CYCLES   = 500;      // long receiver hold-off
  localparam int SETTLE_CYCLES = 24;       // quiet time before a settings change
  localparam int LIMIT_CYCLES  = 3_000_000;
  localparam int PHASE_ITEMS   = 46;
  // addresses past the register map, writes there must change nothing
  localparam logic [CFG_AW-1:0] SPARE_ADDR_LO = CFG_AW'(24);
  localparam logic [CFG_AW-1:0] SPARE_ADDR_HI = CFG_AW'(28);

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;     // [7:0] servo_id, [17:8] start_pos,
                                        // [27:18] goal_pos, [31:28] zero
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;    // [7:0] cmd_servo, [17:8] cmd_pos,
                                        // [33:18] cmd_time, [39:34] zero
  logic                   out_tlast;    // last_cmd
  logic                   cfg_psel;
  logic                   cfg_penable;
  logic                   cfg_pwrite;
  logic [CFG_AW-1:0]      cfg_paddr;
  logic [CFG_DW-1:0]      cfg_pwdata;
  logic [CFG_DW-1:0]      cfg_prdata;
  logic                   cfg_pready;

  profile_checker board;
  int send_idle_pct;   // chance per cycle that the sender sits idle
  int stall_pct;       // chance per cycle that the receiver stalls
  int hold_requests;   // bumped by the stimulus to ask for a long hold-off

  servo_scurve_step_profile dut (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Watchdog: sized for every request giving its full run of commands with
  // stalls on every transfer, then taken several times over.
  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("FAILURE");
    $finish;
  end

  // Monitors: a transfer happens at an edge where valid and ready were both
  // high, so the values read right after the edge are the ones that counted.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) board.note_request(in_tdata);
      if (out_tvalid && out_tready) board.check_command(out_tdata, out_tlast);
    end
  end

  // Receiver: random stalls at the current rate; a hold-off request holds
  // tready low so the queue fills and in_tready drops.
  initial begin : sink
    int hold_left;
    int served;
    hold_left = 0;
    served    = 0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (served != hold_requests) begin
        served    = hold_requests;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  function automatic logic [CFG_AW-1:0] reg_addr(reg_idx_t idx);
    return CFG_AW'(idx) << 2;
  endfunction

  // APB write: setup, then access; the register takes the value at the edge
  // where the access phase meets pready.
  task automatic cfg_write(input logic [CFG_AW-1:0] addr, input logic [CFG_DW-1:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    board.write_reg(addr, value);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  // junk above each field width checks that the register keeps only its bits
  task automatic apply_settings(input int factor, input int t_min, input int t_max,
                                input int steps, input int slow_ms, input int fast_ms);
    cfg_write(reg_addr(REG_MS_PER_UNIT), ($urandom << FACTOR_W) | factor);
    cfg_write(reg_addr(REG_TIME_FLOOR), ($urandom << TIME_W) | t_min);
    cfg_write(reg_addr(REG_TIME_CEIL), ($urandom << TIME_W) | t_max);
    cfg_write(reg_addr(REG_STEP_COUNT), ($urandom << STEP_CFG_W) | steps);
    cfg_write(reg_addr(REG_SLOW_DELAY), ($urandom << TIME_W) | slow_ms);
    cfg_write(reg_addr(REG_FAST_DELAY), ($urandom << TIME_W) | fast_ms);
  endtask

  // One request transfer. tvalid is left high afterwards; the next call
  // either lowers it for an idle gap or presents the next request.
  task automatic send_move(input logic [ID_W-1:0] id, input logic [POS_W-1:0] from_pos,
                           input logic [POS_W-1:0] to_pos);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {4'b0, to_pos, from_pos, id};
    do @(posedge clk); while (!in_tready);
  endtask

  // Mostly short and long moves with random ends; a tenth fully random.
  task automatic send_random_move();
    int unsigned from_pos, to_pos, span, pick;
    from_pos = $urandom_range(POS_MAX);
    pick     = $urandom_range(99);
    if (pick < 40) begin
      span = $urandom_range(NEAR_LIMIT - 1);
      if ($urandom_range(1))
        to_pos = (from_pos + span > POS_MAX) ? from_pos - span : from_pos + span;
      else
        to_pos = (from_pos < span) ? from_pos + span : from_pos - span;
    end else if (pick < 90) begin
      do to_pos = $urandom_range(POS_MAX);
      while ((to_pos > from_pos ? to_pos - from_pos : from_pos - to_pos) < NEAR_LIMIT);
    end else begin
      to_pos = $urandom_range(POS_MAX);
    end
    send_move(ID_W'($urandom_range(255)), POS_W'(from_pos), POS_W'(to_pos));
  endtask

  // Stop offering and wait for every planned command, then let the step
  // engine settle before anything touches the registers.
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic random_moves(input int count);
    repeat (count) send_random_move();
  endtask

  initial begin
    board         = new();
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_requests = 0;
    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed, reset settings: zero distance, both ends of the position
    // and id ranges, the short/long boundary in both directions, full sweeps.
    send_move(8'd0, 10'd0, 10'd0);
    send_move(8'd255, 10'd1023, 10'd1023);
    send_move(8'd1, 10'd100, 10'd101);
    send_move(8'd2, 10'd100, 10'd149);
    send_move(8'd3, 10'd149, 10'd100);
    send_move(8'd4, 10'd0, 10'd50);
    send_move(8'd5, 10'd50, 10'd0);
    send_move(8'd170, 10'd0, 10'd1023);
    send_move(8'd85, 10'd1023, 10'd0);
    send_move(8'd6, 10'd512, 10'd511);
    send_move(8'd7, 10'd300, 10'd359);
    drain();

    // extremes: widest clamps, most steps, full delay span; the step count
    // of 64 with a short long-move makes the run stop before the last step
    apply_settings(255, 0, 65535, 64, 65535, 0);
    cfg_write(SPARE_ADDR_LO, $urandom);
    cfg_write(SPARE_ADDR_HI, $urandom);
    send_move(8'd8, 10'd0, 10'd50);
    send_move(8'd9, 10'd1000, 10'd937);
    send_move(8'd10, 10'd0, 10'd49);
    send_move(8'd11, 10'd1023, 10'd0);
    // receiver holds off while the sender keeps going: queue fills up
    hold_requests++;
    random_moves(PHASE_ITEMS);
    drain();

    // crossed clamp bounds, step count 2, delays rising instead of falling
    apply_settings(0, 65535, 0, 2, 0, 65535);
    send_move(8'd12, 10'd40, 10'd40);
    send_move(8'd13, 10'd0, 10'd1023);
    send_move(8'd14, 10'd700, 10'd651);
    send_idle_pct = 68;
    random_moves(PHASE_ITEMS);
    drain();

    // random settings, step count anywhere in its field, receiver stalls;
    // a full drain in the middle pauses the sender until all is returned
    apply_settings($urandom_range(255), $urandom_range(65535), $urandom_range(65535),
                   $urandom_range(127), $urandom_range(65535), $urandom_range(65535));
    send_idle_pct = 0;
    stall_pct     = 68;
    random_moves(PHASE_ITEMS / 2);
    drain();
    random_moves(PHASE_ITEMS / 2);
    drain();

    // step count below range saturates to 2, flat delays, narrow clamps
    apply_settings(37, 500, 600, 0, 1000, 1000);
    send_idle_pct = 26;
    stall_pct     = 26;
    random_moves(PHASE_ITEMS / 2);
    drain();
    cfg_write(reg_addr(REG_STEP_COUNT), 1);
    random_moves(PHASE_ITEMS / 2);
    drain();

    // step count above range saturates to the maximum, no idling at all
    apply_settings($urandom_range(255), $urandom_range(2000), $urandom_range(65535),
                   127, $urandom_range(65535), $urandom_range(65535));
    send_idle_pct = 0;
    stall_pct     = 0;
    random_moves(PHASE_ITEMS);
    drain();

    if (board.errors == 0 && board.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl
rtl/sscp_pkg.sv
rtl/sscp_front.sv
rtl/sscp_fifo.sv
rtl/sscp_back.sv
rtl/servo_scurve_step_profile.sv
tb/servo_scurve_step_profile_tb.sv
